/* sv/fcbt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcbt_pkg
// Shared types and constants of the fixed-capacity bag table.
// ----------------------------------------------------------------------------
package fcbt_pkg;

  localparam int unsigned DefCapacity = 8;
  localparam int unsigned DefKeyWidth = 32;

  localparam int unsigned OpcodeW   = 2;
  localparam int unsigned KeyFieldW = 32;
  localparam int unsigned InTdataW  = 40;
  localparam int unsigned ResCntW   = 4;
  localparam int unsigned OutTdataW = 16;

  typedef enum logic [OpcodeW-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_e;

  // request control that travels down the cell row with the key
  typedef struct packed {
    opcode_e op;
    logic    distinct;
    logic    found;
    logic    hole;
    logic    settled;
    logic    stored;
  } fcbt_ctl_t;

endpackage

/* sv/fcbt_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcbt_cell
// One table slot: holds an entry, works on the request passing through and
// hands the request to the next slot.
// ----------------------------------------------------------------------------
module fcbt_cell import fcbt_pkg::*; #(
  parameter int unsigned KEY_WIDTH = DefKeyWidth,
  parameter int unsigned CNT_W     = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 tok_i,
  input  fcbt_ctl_t            ctl_i,
  input  logic [KEY_WIDTH-1:0] key_i,
  input  logic [CNT_W-1:0]     cnt_i,
  input  logic                 nxt_vld_i,
  input  logic [KEY_WIDTH-1:0] nxt_key_i,
  input  logic                 pull_i,
  output logic                 tok_o,
  output fcbt_ctl_t            ctl_o,
  output logic [KEY_WIDTH-1:0] key_o,
  output logic [CNT_W-1:0]     cnt_o,
  output logic                 vld_o,
  output logic [KEY_WIDTH-1:0] ent_o,
  output logic                 pull_o
);

  logic                 tok_q;
  fcbt_ctl_t            ctl_q, ctl_d;
  logic [KEY_WIDTH-1:0] key_q;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 vld_q, vld_d;
  logic [KEY_WIDTH-1:0] ent_q, ent_d;
  logic                 hit;

  assign hit    = vld_q && (ent_q == key_i);
  assign pull_o = tok_i && (ctl_i.op == OP_REMOVE) && ctl_i.hole;

  always_comb begin
    ctl_d = ctl_i;
    cnt_d = cnt_i;
    vld_d = vld_q;
    ent_d = ent_q;
    if (tok_i) begin
      unique case (ctl_i.op)
        OP_ADD: begin
          if (hit) begin
            cnt_d       = cnt_i + CNT_W'(1);
            ctl_d.found = 1'b1;
          end else if (!vld_q && !ctl_i.settled) begin
            ctl_d.settled = 1'b1;
            if (!(ctl_i.distinct && ctl_i.found)) begin
              vld_d        = 1'b1;
              ent_d        = key_i;
              ctl_d.stored = 1'b1;
            end
          end
        end
        OP_REMOVE: begin
          if (ctl_i.hole) begin
            vld_d = 1'b0;
          end else if (hit) begin
            ctl_d.found = 1'b1;
            ctl_d.hole  = 1'b1;
            vld_d       = 1'b0;
          end
        end
        OP_QUERY: begin
          if (hit) begin
            cnt_d       = cnt_i + CNT_W'(1);
            ctl_d.found = 1'b1;
          end
        end
        OP_CLEAR: begin
          vld_d = 1'b0;
        end
        default: begin
          vld_d = vld_q;
        end
      endcase
    end
    // close the gap left by a removed entry
    if (pull_i) begin
      vld_d = nxt_vld_i;
      ent_d = nxt_key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
      vld_q <= 1'b0;
    end else begin
      tok_q <= tok_i;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ctl_q <= ctl_d;
    key_q <= key_i;
    cnt_q <= cnt_d;
    ent_q <= ent_d;
  end

  assign tok_o = tok_q;
  assign ctl_o = ctl_q;
  assign key_o = key_q;
  assign cnt_o = cnt_q;
  assign vld_o = vld_q;
  assign ent_o = ent_q;

endmodule

/* sv/fixed_capacity_bag_table_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_capacity_bag_table_top
// Bag of keys kept in a row of slots; a request walks the row one slot a cycle.
//
//   channel   dir  fields (low bit first)
//   s_axis    in   opcode[1:0], key[33:2], zero pad to 40 bits
//   m_axis    out  ok[0], match_count[4:1], size[8:5], empty_res[9], zero pad
//   cfg       in   distinct_mode (write enable + data, no read-back)
//
// One request at a time: the result comes from the walk down the slot row, then
// a hand-off register and the output register.
// The next request is taken once the result sits in the output register.
// A stalled result holds in the output register; the row waits behind it.
// Reset empties the table and sets distinct mode.
// ----------------------------------------------------------------------------
module fixed_capacity_bag_table_top import fcbt_pkg::*; #(
  parameter int unsigned CAPACITY  = DefCapacity,
  parameter int unsigned KEY_WIDTH = DefKeyWidth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_wr_en_i,
  input  logic                 cfg_wr_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InTdataW-1:0]  s_axis_tdata,   // opcode, key
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutTdataW-1:0] m_axis_tdata    // ok, match_count, size, empty_res
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic                 tok_w  [CAPACITY+1];
  fcbt_ctl_t            ctl_w  [CAPACITY+1];
  logic [KEY_WIDTH-1:0] key_w  [CAPACITY+1];
  logic [CntW-1:0]      cnt_w  [CAPACITY+1];
  logic                 vld_w  [CAPACITY+1];
  logic [KEY_WIDTH-1:0] ent_w  [CAPACITY+1];
  logic                 pull_w [CAPACITY+1];

  logic            distinct_q;
  logic            busy_q;
  logic            pend_vld_q;
  fcbt_ctl_t       pend_ctl_q;
  logic [CntW-1:0] pend_cnt_q;
  logic [CntW-1:0] size_q, size_d;
  logic            load;
  logic            res_ok;
  logic            out_vld_q;
  logic [OutTdataW-1:0] out_data_q, out_data_d;

  assign s_axis_tready = !busy_q;

  assign tok_w[0] = s_axis_tvalid && s_axis_tready;
  assign ctl_w[0] = '{op:       opcode_e'(s_axis_tdata[OpcodeW-1:0]),
                      distinct: distinct_q,
                      found:    1'b0,
                      hole:     1'b0,
                      settled:  1'b0,
                      stored:   1'b0};
  assign key_w[0] = KEY_WIDTH'(s_axis_tdata[OpcodeW +: KeyFieldW]);
  assign cnt_w[0] = '0;

  assign vld_w[CAPACITY]  = 1'b0;
  assign ent_w[CAPACITY]  = '0;
  assign pull_w[CAPACITY] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    fcbt_cell #(
      .KEY_WIDTH (KEY_WIDTH),
      .CNT_W     (CntW)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .tok_i     (tok_w[i]),
      .ctl_i     (ctl_w[i]),
      .key_i     (key_w[i]),
      .cnt_i     (cnt_w[i]),
      .nxt_vld_i (vld_w[i+1]),
      .nxt_key_i (ent_w[i+1]),
      .pull_i    (pull_w[i+1]),
      .tok_o     (tok_w[i+1]),
      .ctl_o     (ctl_w[i+1]),
      .key_o     (key_w[i+1]),
      .cnt_o     (cnt_w[i+1]),
      .vld_o     (vld_w[i]),
      .ent_o     (ent_w[i]),
      .pull_o    (pull_w[i])
    );
  end

  assign load = pend_vld_q && (!out_vld_q || m_axis_tready);

  always_comb begin
    size_d = size_q;
    res_ok = 1'b0;
    unique case (pend_ctl_q.op)
      OP_ADD: begin
        res_ok = pend_ctl_q.stored;
        if (pend_ctl_q.stored) begin
          size_d = size_q + CntW'(1);
        end
      end
      OP_REMOVE: begin
        res_ok = pend_ctl_q.found;
        if (pend_ctl_q.found) begin
          size_d = size_q - CntW'(1);
        end
      end
      OP_QUERY: begin
        res_ok = pend_ctl_q.found;
      end
      OP_CLEAR: begin
        res_ok = 1'b1;
        size_d = '0;
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
    out_data_d = '0;
    out_data_d[0]   = res_ok;
    out_data_d[4:1] = (pend_ctl_q.op == OP_QUERY) ? ResCntW'(pend_cnt_q) : '0;
    out_data_d[8:5] = ResCntW'(size_d);
    out_data_d[9]   = (size_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      distinct_q <= 1'b1;
      busy_q     <= 1'b0;
      pend_vld_q <= 1'b0;
      size_q     <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        distinct_q <= cfg_wr_data_i;
      end
      if (tok_w[0]) begin
        busy_q <= 1'b1;
      end else if (load) begin
        busy_q <= 1'b0;
      end
      if (tok_w[CAPACITY]) begin
        pend_vld_q <= 1'b1;
      end else if (load) begin
        pend_vld_q <= 1'b0;
      end
      if (load) begin
        size_q    <= size_d;
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_w[CAPACITY]) begin
      pend_ctl_q <= ctl_w[CAPACITY];
      pend_cnt_q <= cnt_w[CAPACITY];
    end
    if (load) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

/* sv/fcbt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcbt_checker
// Port-level checks of the bag table, bound to the top level.
// ----------------------------------------------------------------------------
module fcbt_checker import fcbt_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 cfg_wr_en_i,
  input logic                 cfg_wr_data_i,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [InTdataW-1:0]  s_axis_tdata,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [OutTdataW-1:0] m_axis_tdata
);

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request taken while another is in flight");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[9] == (m_axis_tdata[8:5] == 4'd0)))
    else $error("empty flag disagrees with size");

  a_count_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[4:1] == 4'd0) || m_axis_tdata[0]))
    else $error("match count without ok");

endmodule

bind fixed_capacity_bag_table_top fcbt_checker u_fcbt_checker (.*);

/* test/fixed_capacity_bag_table_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_capacity_bag_table_top_test
// Self-checking bench for the fixed-capacity bag table.
//
// A directed table covers the empty, full, duplicate and clear cases spread
// over both modes, with the plain results typed in. Random add, remove, query
// and clear requests on a small key pool follow in three flow-control phases,
// with mode changes between segments; the rest check against a bag predictor.
// ----------------------------------------------------------------------------
module fixed_capacity_bag_table_top_test;
  import fcbt_pkg::*;

  localparam int unsigned Capacity   = DefCapacity;
  localparam int unsigned Latency    = DefCapacity + 2;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned PoolSize   = 5;
  localparam int unsigned SegItems   = 100;
  localparam longint      TimeoutNs  = 64'd12_000_000;

  localparam int unsigned OkBit    = 0;
  localparam int unsigned CountLsb = 1;
  localparam int unsigned SizeLsb  = 5;
  localparam int unsigned EmptyBit = 9;

  localparam logic MODE_BAG = 1'b0;
  localparam logic MODE_SET = 1'b1;

  typedef enum logic {ROW_REQUEST, ROW_MODE} row_kind_e;

  typedef struct packed {
    logic       ok;
    logic [3:0] match_count;
    logic [3:0] size;
    logic       empty_res;
  } bag_result_t;

  typedef struct packed {
    row_kind_e   kind;
    logic        mode_val;
    opcode_e     op;
    logic [31:0] key;
    logic        typed;
    bag_result_t want;
  } directed_row_t;

  localparam int unsigned NumRows = 23;
  localparam directed_row_t Directed [NumRows] = '{
    '{ROW_REQUEST, MODE_SET, OP_QUERY,  32'h0000_0000, 1'b1, '{1'b0, 4'd0, 4'd0, 1'b1}},
    '{ROW_REQUEST, MODE_SET, OP_REMOVE, 32'hFFFF_FFFF, 1'b1, '{1'b0, 4'd0, 4'd0, 1'b1}},
    '{ROW_REQUEST, MODE_SET, OP_ADD,    32'h0000_0000, 1'b1, '{1'b1, 4'd0, 4'd1, 1'b0}},
    '{ROW_REQUEST, MODE_SET, OP_ADD,    32'h0000_0000, 1'b1, '{1'b0, 4'd0, 4'd1, 1'b0}},
    '{ROW_REQUEST, MODE_SET, OP_ADD,    32'hFFFF_FFFF, 1'b1, '{1'b1, 4'd0, 4'd2, 1'b0}},
    '{ROW_REQUEST, MODE_SET, OP_QUERY,  32'hFFFF_FFFF, 1'b1, '{1'b1, 4'd1, 4'd2, 1'b0}},
    '{ROW_REQUEST, MODE_SET, OP_REMOVE, 32'h0000_0000, 1'b0, '0},
    '{ROW_REQUEST, MODE_SET, OP_REMOVE, 32'h0000_0000, 1'b0, '0},
    '{ROW_REQUEST, MODE_SET, OP_CLEAR,  32'h0000_0000, 1'b1, '{1'b1, 4'd0, 4'd0, 1'b1}},
    '{ROW_MODE,    MODE_BAG, OP_ADD,    32'h0000_0000, 1'b0, '0},
    '{ROW_REQUEST, MODE_BAG, OP_ADD,    32'hCAFE_F00D, 1'b1, '{1'b1, 4'd0, 4'd1, 1'b0}},
    '{ROW_REQUEST, MODE_BAG, OP_ADD,    32'hCAFE_F00D, 1'b1, '{1'b1, 4'd0, 4'd2, 1'b0}},
    '{ROW_REQUEST, MODE_BAG, OP_ADD,    32'hCAFE_F00D, 1'b1, '{1'b1, 4'd0, 4'd3, 1'b0}},
    '{ROW_REQUEST, MODE_BAG, OP_ADD,    32'hCAFE_F00D, 1'b1, '{1'b1, 4'd0, 4'd4, 1'b0}},
    '{ROW_REQUEST, MODE_BAG, OP_ADD,    32'hCAFE_F00D, 1'b1, '{1'b1, 4'd0, 4'd5, 1'b0}},
    '{ROW_REQUEST, MODE_BAG, OP_ADD,    32'hCAFE_F00D, 1'b1, '{1'b1, 4'd0, 4'd6, 1'b0}},
    '{ROW_REQUEST, MODE_BAG, OP_ADD,    32'hCAFE_F00D, 1'b1, '{1'b1, 4'd0, 4'd7, 1'b0}},
    '{ROW_REQUEST, MODE_BAG, OP_ADD,    32'hCAFE_F00D, 1'b1, '{1'b1, 4'd0, 4'd8, 1'b0}},
    '{ROW_REQUEST, MODE_BAG, OP_ADD,    32'hCAFE_F00D, 1'b1, '{1'b0, 4'd0, 4'd8, 1'b0}},
    '{ROW_REQUEST, MODE_BAG, OP_QUERY,  32'hCAFE_F00D, 1'b1, '{1'b1, 4'd8, 4'd8, 1'b0}},
    '{ROW_REQUEST, MODE_BAG, OP_REMOVE, 32'hCAFE_F00D, 1'b0, '0},
    '{ROW_REQUEST, MODE_BAG, OP_CLEAR,  32'h0000_0000, 1'b1, '{1'b1, 4'd0, 4'd0, 1'b1}},
    '{ROW_MODE,    MODE_SET, OP_ADD,    32'h0000_0000, 1'b0, '0}
  };

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_wr_en_i   = 1'b0;
  logic                 cfg_wr_data_i = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;

  logic [31:0]  held_keys [Capacity];
  int unsigned  held_count  = 0;
  logic         distinct_on = MODE_SET;
  bag_result_t  pending_results [$];
  int unsigned  mismatch_count = 0;

  int unsigned  src_idle_pct  = 7;
  int unsigned  sink_idle_pct = 74;
  int unsigned  hold_order    = 0;
  int unsigned  hold_seen     = 0;
  int unsigned  hold_left     = 0;

  fixed_capacity_bag_table_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  function automatic bag_result_t apply_request(opcode_e op, logic [31:0] key);
    bag_result_t res;
    int          hit;
    int unsigned match_total;
    int unsigned n;
    res         = '0;
    hit         = -1;
    match_total = 0;
    n           = held_count;
    for (int i = 0; i < n; i++) begin
      if (held_keys[i] == key) begin
        if (hit < 0) hit = i;
        match_total++;
      end
    end
    case (op)
      OP_ADD: begin
        if (n < Capacity && !(distinct_on && hit >= 0)) begin
          held_keys[n] = key;
          n++;
          res.ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (hit >= 0) begin
          n--;
          held_keys[hit] = held_keys[n];
          res.ok = 1'b1;
        end
      end
      OP_QUERY: begin
        res.match_count = match_total[3:0];
        res.ok = (match_total > 0);
      end
      default: begin
        n = 0;
        res.ok = 1'b1;
      end
    endcase
    held_count    = n;
    res.size      = n[3:0];
    res.empty_res = (n == 0);
    return res;
  endfunction

  task automatic send_request(opcode_e op, logic [31:0] key, logic typed, bag_result_t want);
    bag_result_t predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InTdataW - KeyFieldW - OpcodeW){1'b0}}, key, op};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = apply_request(op, key);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_mode(logic mode);
    drain_results();
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= mode;
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    distinct_on = mode;
  endtask

  always @(posedge clk_i) begin
    if (hold_order != hold_seen) begin
      hold_seen = hold_order;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    bag_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with none pending: tdata %h", m_axis_tdata);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[OkBit] !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, m_axis_tdata[OkBit]);
          mismatch_count++;
        end
        if (m_axis_tdata[CountLsb +: 4] !== want.match_count) begin
          $error("match_count: expected %0d, got %0d", want.match_count,
                 m_axis_tdata[CountLsb +: 4]);
          mismatch_count++;
        end
        if (m_axis_tdata[SizeLsb +: 4] !== want.size) begin
          $error("size: expected %0d, got %0d", want.size, m_axis_tdata[SizeLsb +: 4]);
          mismatch_count++;
        end
        if (m_axis_tdata[EmptyBit] !== want.empty_res) begin
          $error("empty_res: expected %0d, got %0d", want.empty_res,
                 m_axis_tdata[EmptyBit]);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [31:0]  key_pool [PoolSize];
    logic [31:0]  key;
    opcode_e      op;
    int unsigned  pick;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (Directed[i]) begin
      if (Directed[i].kind == ROW_MODE) begin
        set_mode(Directed[i].mode_val);
      end else begin
        send_request(Directed[i].op, Directed[i].key, Directed[i].typed, Directed[i].want);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct  = (ph == 0) ? 7 : (ph == 1) ? 74 : 0;
      sink_idle_pct = (ph == 0) ? 74 : (ph == 1) ? 7 : 0;
      for (int seg = 0; seg < 5; seg++) begin
        set_mode((seg % 2 == 0) ? MODE_BAG : MODE_SET);
        foreach (key_pool[j]) begin
          pick = $urandom_range(9);
          key_pool[j] = (pick == 0) ? 32'h0000_0000 :
                        (pick == 1) ? 32'hFFFF_FFFF : $urandom;
        end
        if (seg == 1) hold_order++;
        for (int n = 0; n < SegItems; n++) begin
          if (seg == 3 && n == SegItems / 2) drain_results();
          pick = $urandom_range(99);
          op   = (pick < 45) ? OP_ADD : (pick < 70) ? OP_REMOVE :
                 (pick < 95) ? OP_QUERY : OP_CLEAR;
          key  = ($urandom_range(99) < 85) ? key_pool[$urandom_range(PoolSize - 1)]
                                           : $urandom;
          send_request(op, key, 1'b0, '0);
        end
      end
    end

    drain_results();
    repeat (Latency + 2) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeoutNs);
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* fixed_capacity_bag_table_top.f */
sv/fcbt_pkg.sv
sv/fcbt_cell.sv
sv/fixed_capacity_bag_table_top.sv
sv/fcbt_checker.sv
test/fixed_capacity_bag_table_top_test.sv
